>>> design/chr_pkg.sv
// ----------------------------------------------------------------------------
// chr_pkg
// Shared widths, constants and register codes for the cubic Hermite resampler.
// ----------------------------------------------------------------------------
package chr_pkg;

	localparam int FRAC_BITS = 16;

	localparam int FRAME_W = 32;
	localparam int SMP_W   = 24;
	localparam int RATE_W  = 20;
	localparam int MODE_W  = 2;
	localparam int PH_W    = FRAC_BITS + 4;
	localparam int SUM_W   = ((PH_W > RATE_W) ? PH_W : RATE_W) + 1;

	// coefficient and accumulator widths follow from the 24-bit samples
	localparam int K3_W = 27;
	localparam int K2_W = 28;
	localparam int K1_W = 25;
	localparam int A_W  = 30;
	localparam int F_W  = FRAC_BITS + 1;
	localparam int P_W  = A_W + F_W;
	localparam int V_W  = P_W + 1;

	localparam int MAX_RES = 64;
	localparam int CNT_W   = $clog2(MAX_RES);

	localparam int SMP_MIN = -8388608;
	localparam int SMP_MAX = 8388352;

	localparam logic [SUM_W-1:0] ONE    = SUM_W'(1) << FRAC_BITS;
	localparam logic [SUM_W-1:0] PH_MAX = (SUM_W'(1) << PH_W) - SUM_W'(1);
	localparam logic [V_W-1:0]   TRUNC_BIAS = (V_W'(1) << (FRAC_BITS + 1)) - V_W'(1);

	localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(65536);

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic REG_RATE = 1'b0;
	localparam logic REG_MODE = 1'b1;

	localparam logic [MODE_W-1:0] CM_AVG   = 2'd0;
	localparam logic [MODE_W-1:0] CM_LEFT  = 2'd1;
	localparam logic [MODE_W-1:0] CM_RIGHT = 2'd2;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DISP = 8'b0000_0010,
		S_COEF = 8'b0000_0100,
		S_MUL  = 8'b0000_1000,
		S_ACC  = 8'b0001_0000,
		S_SUM  = 8'b0010_0000,
		S_FIN  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

endpackage

>>> design/chr_in_if.sv
// ----------------------------------------------------------------------------
// chr_in_if
// Input channel: one stereo frame word and its restart mark.
// ----------------------------------------------------------------------------
interface chr_in_if;
	import chr_pkg::*;

	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] frame;
	logic               restart;

	modport source (output valid, output frame, output restart, input ready);
	modport sink   (input valid, input frame, input restart, output ready);

endinterface

>>> design/chr_out_if.sv
// ----------------------------------------------------------------------------
// chr_out_if
// Output channel: one interpolated sample and its last-of-frame mark.
// ----------------------------------------------------------------------------
interface chr_out_if;
	import chr_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample;
	logic                    last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);

endinterface

>>> design/cubic_hermite_resampler_core.sv
// ----------------------------------------------------------------------------
// cubic_hermite_resampler_core
// a frame is taken only in the idle state, then passes dispatch, coefficients,
// multiply/accumulate steps on the one shared multiplier and its sequencer,
// sum, finish and output; each further word of the frame repeats from multiply;
// bypass goes from dispatch straight to output, frames with no word to idle
// reset: async, clears control, window and phase, priming restarts, rate 1.0
// ----------------------------------------------------------------------------
module cubic_hermite_resampler_core (
	input  logic                       clk,
	input  logic                       arst_n,
	chr_in_if.sink                     din,
	chr_out_if.source                  dout,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [chr_pkg::APB_AW-1:0] paddr,
	input  logic [chr_pkg::APB_DW-1:0] pwdata,
	output logic [chr_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import chr_pkg::*;

	state_t state_q;

	logic [RATE_W-1:0] rate_q;
	logic [MODE_W-1:0] mode_q;

	logic signed [SMP_W-1:0] w_q [4];
	logic [PH_W-1:0]         phase_q;
	logic [1:0]              primes_q;

	logic signed [SMP_W-1:0] v_q;
	logic                    restart_q;

	logic signed [K3_W-1:0] k3_q;
	logic signed [K2_W-1:0] k2_q;
	logic signed [K1_W-1:0] k1_q;
	logic signed [A_W-1:0]  a_q;
	logic signed [P_W-1:0]  prod_q;
	logic signed [V_W-1:0]  vsum_q;
	logic [1:0]             step_q;
	logic [CNT_W-1:0]       cnt_q;

	logic signed [SMP_W-1:0] res_q;
	logic                    res_last_q;

	logic                    out_vld_q;
	logic signed [SMP_W-1:0] out_smp_q;
	logic                    out_last_q;

	// ---------------- configuration port ----------------
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_MODE) ? APB_DW'(mode_q) : APB_DW'(rate_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RST;
			mode_q <= CM_AVG;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_RATE: rate_q <= pwdata[RATE_W-1:0];
				REG_MODE: mode_q <= pwdata[MODE_W-1:0];
				default:  rate_q <= rate_q;
			endcase
		end
	end

	// ---------------- channel pick ----------------
	logic signed [15:0]      lo, hi;
	logic signed [16:0]      lr_sum;
	logic signed [SMP_W-1:0] pick;

	assign lo     = din.frame[15:0];
	assign hi     = din.frame[31:16];
	assign lr_sum = 17'(lo) + 17'(hi);

	always_comb begin
		case (mode_q)
			CM_LEFT:  pick = {lo, 8'h00};
			CM_RIGHT: pick = {hi, 8'h00};
			default:  pick = {lr_sum, 7'b0};
		endcase
	end

	// ---------------- datapath helpers ----------------
	logic signed [K3_W-1:0] e0, e1, e2, e3, d12, k3_c;
	logic signed [K2_W-1:0] g0, g1, g2, g3, k2_c;
	logic signed [K1_W-1:0] k1_c;

	assign e0   = K3_W'(w_q[0]);
	assign e1   = K3_W'(w_q[1]);
	assign e2   = K3_W'(w_q[2]);
	assign e3   = K3_W'(w_q[3]);
	assign d12  = e1 - e2;
	assign k3_c = d12 + (d12 <<< 1) - e0 + e3;
	assign g0   = K2_W'(w_q[0]);
	assign g1   = K2_W'(w_q[1]);
	assign g2   = K2_W'(w_q[2]);
	assign g3   = K2_W'(w_q[3]);
	assign k2_c = (g2 <<< 2) + (g0 <<< 1) - (g1 <<< 2) - g1 - g3;
	assign k1_c = K1_W'(w_q[2]) - K1_W'(w_q[0]);

	// the shared multiplier
	logic signed [F_W-1:0] f_s;
	logic signed [P_W-1:0] prod_c;

	assign f_s    = signed'({1'b0, phase_q[FRAC_BITS-1:0]});
	assign prod_c = a_q * f_s;

	logic signed [P_W-1:0] prod_sh;
	logic signed [A_W-1:0] acc_add, acc_c;

	assign prod_sh = prod_q >>> FRAC_BITS;
	assign acc_add = (step_q == 2'd0) ? A_W'(k2_q) : A_W'(k1_q);
	assign acc_c   = A_W'(prod_sh) + acc_add;

	logic signed [V_W-1:0] vsum_c, vbias, vq;

	assign vsum_c = V_W'(prod_q) + (V_W'(w_q[1]) <<< (FRAC_BITS + 1));
	assign vbias  = vsum_q + (vsum_q[V_W-1] ? signed'(TRUNC_BIAS) : V_W'(0));
	assign vq     = vbias >>> (FRAC_BITS + 1);

	logic signed [SMP_W-1:0] clamp_c;

	always_comb begin
		if (vq < SMP_MIN)
			clamp_c = SMP_W'(SMP_MIN);
		else if (vq > SMP_MAX)
			clamp_c = SMP_W'(SMP_MAX);
		else
			clamp_c = SMP_W'(vq);
	end

	// phase arithmetic
	logic [SUM_W-1:0] ph_sum, ph_sat;
	logic [PH_W-1:0]  ph_dec;
	logic             ph_dec_lt;

	assign ph_sum    = SUM_W'(phase_q) + SUM_W'(rate_q);
	assign ph_sat    = (ph_sum > PH_MAX) ? PH_MAX : ph_sum;
	assign ph_dec    = (SUM_W'(phase_q) >= ONE) ? (phase_q - PH_W'(ONE)) : PH_W'(0);
	assign ph_dec_lt = SUM_W'(ph_dec) < ONE;

	logic       bypass;
	logic [1:0] primes_eff;
	logic       slot_free;
	logic       out_load;

	assign bypass     = SUM_W'(rate_q) == ONE;
	assign primes_eff = restart_q ? 2'd3 : primes_q;
	assign slot_free  = !out_vld_q || dout.ready;
	assign out_load   = (state_q == S_OUT) && slot_free;

	assign din.ready = (state_q == S_IDLE);

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (dout.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			w_q[0]     <= '0;
			w_q[1]     <= '0;
			w_q[2]     <= '0;
			w_q[3]     <= '0;
			phase_q    <= '0;
			primes_q   <= 2'd3;
			step_q     <= '0;
			cnt_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (din.valid) begin
						v_q       <= pick;
						restart_q <= din.restart;
						state_q   <= S_DISP;
					end
				end
				S_DISP: begin
					cnt_q <= '0;
					if (bypass) begin
						res_q      <= v_q;
						res_last_q <= 1'b1;
						primes_q   <= 2'd3;
						state_q    <= S_OUT;
					end else if (primes_eff != 2'd0) begin
						case (primes_eff)
							2'd3:    w_q[1] <= v_q;
							2'd2:    w_q[2] <= v_q;
							default: w_q[3] <= v_q;
						endcase
						primes_q <= primes_eff - 2'd1;
						if (primes_eff == 2'd1) begin
							phase_q <= '0;
							state_q <= S_COEF;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						w_q[0]  <= w_q[1];
						w_q[1]  <= w_q[2];
						w_q[2]  <= w_q[3];
						w_q[3]  <= v_q;
						phase_q <= ph_dec;
						state_q <= ph_dec_lt ? S_COEF : S_IDLE;
					end
				end
				S_COEF: begin
					k3_q    <= k3_c;
					k2_q    <= k2_c;
					k1_q    <= k1_c;
					a_q     <= A_W'(k3_c);
					step_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= prod_c;
					state_q <= (step_q == 2'd2) ? S_SUM : S_ACC;
				end
				S_ACC: begin
					a_q     <= acc_c;
					step_q  <= step_q + 2'd1;
					state_q <= S_MUL;
				end
				S_SUM: begin
					vsum_q  <= vsum_c;
					state_q <= S_FIN;
				end
				S_FIN: begin
					res_q      <= clamp_c;
					phase_q    <= PH_W'(ph_sat);
					res_last_q <= (ph_sat >= ONE) || (cnt_q == CNT_W'(MAX_RES - 1));
					cnt_q      <= cnt_q + CNT_W'(1);
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (slot_free) begin
						out_smp_q  <= res_q;
						out_last_q <= res_last_q;
						if (res_last_q) begin
							state_q <= S_IDLE;
						end else begin
							a_q     <= A_W'(k3_q);
							step_q  <= '0;
							state_q <= S_MUL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign dout.valid  = out_vld_q;
	assign dout.sample = out_smp_q;
	assign dout.last   = out_last_q;

	// ---------------- assertions ----------------
	a_take_to_disp: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> state_q == S_DISP)
		else $error("taken word did not reach dispatch");

	a_mul_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> SUM_W'(phase_q) < ONE)
		else $error("interpolating at phase of one or more");

	a_acc_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |-> step_q < 2'd2)
		else $error("horner step out of range");

	a_out_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !dout.ready |=> out_vld_q && $stable(out_smp_q))
		else $error("pending output word overwritten");

endmodule

>>> test/cubic_hermite_resampler_core_tb.sv
// ----------------------------------------------------------------------------
// cubic_hermite_resampler_core_tb
// Self-checking bench for the cubic Hermite resampler. A directed table covers
// bypass in every channel mode, full-scale frames, priming and restart, a rate
// below the per-frame word cap and the largest rate. It is followed by random
// phases, each with its own rate and channel mode. Every accepted frame runs
// through a bench-side model of the window, phase and interpolation, and each
// output word is compared with the oldest expected word. Both sides idle at
// random, and the output side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module cubic_hermite_resampler_core_tb;
	import chr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned UNITY    = 32'd1 << FRAC_BITS;
	localparam int unsigned PH_TOP   = (32'd1 << PH_W) - 32'd1;
	localparam int          WATCHDOG = 3000;
	localparam int          HOLD_LEN = 300;
	localparam int          SETTLE   = 16;
	localparam int          N_RANDOM = 194;

	// mode code three is decoded like the average
	localparam logic [MODE_W-1:0] CM_AVG_ALT = 2'd3;

	typedef struct {
		logic [SMP_W-1:0] sample;
		logic             last;
	} smp_word_t;

	typedef enum logic [1:0] {ROW_FRAME, ROW_RATE, ROW_MODE} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [31:0]      value;
		logic             restart;
		logic             typed;
		logic [SMP_W-1:0] want;
	} dir_row_t;

	localparam int N_DIR = 33;

	dir_row_t directed_rows [N_DIR] = '{
		// bypass after reset, average of both halves
		'{ROW_FRAME, 32'h7FFF7FFF, 1'b0, 1'b1, 24'h7FFF00},
		'{ROW_FRAME, 32'h80008000, 1'b0, 1'b1, 24'h800000},
		'{ROW_FRAME, 32'h00010000, 1'b0, 1'b1, 24'h000080},
		'{ROW_MODE,  32'(CM_LEFT), 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h00007FFF, 1'b0, 1'b1, 24'h7FFF00},
		'{ROW_FRAME, 32'h7FFF8000, 1'b0, 1'b1, 24'h800000},
		'{ROW_MODE,  32'(CM_RIGHT), 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h80000000, 1'b0, 1'b1, 24'h800000},
		'{ROW_FRAME, 32'h7FFF0000, 1'b0, 1'b1, 24'h7FFF00},
		'{ROW_MODE,  32'(CM_AVG_ALT), 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h00020004, 1'b0, 1'b1, 24'h000300},
		// restart is a no-op in bypass
		'{ROW_FRAME, 32'h00010001, 1'b1, 1'b1, 24'h000100},
		// half rate, full-scale swings push the cubic past the clamp
		'{ROW_RATE,  32'd32768,    1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h10001000, 1'b1, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h20002000, 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h7FFF7FFF, 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h80008000, 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h7FFF7FFF, 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h80008000, 1'b0, 1'b0, 24'h0},
		// restart while still priming
		'{ROW_MODE,  32'(CM_AVG),  1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h01000100, 1'b1, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h02000200, 1'b1, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h03000300, 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h04000400, 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h05000500, 1'b0, 1'b0, 24'h0},
		// word cap hit with the phase still below one
		'{ROW_RATE,  32'd1000,     1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h00FF0100, 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h7FFF8000, 1'b0, 1'b0, 24'h0},
		// largest step
		'{ROW_RATE,  32'd1048575,  1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h12345678, 1'b1, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h9ABCDEF0, 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h7FFF7FFF, 1'b0, 1'b0, 24'h0},
		'{ROW_FRAME, 32'h00000000, 1'b0, 1'b0, 24'h0}
	};

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	chr_in_if  din_if ();
	chr_out_if dout_if ();

	cubic_hermite_resampler_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din_if),
		.dout    (dout_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// resampler state as the bench sees it
	int               win [4];
	int unsigned      phase_acc;
	int               primes_due;
	logic [RATE_W-1:0] cur_rate;
	logic [MODE_W-1:0] cur_mode;

	smp_word_t pending_samples [$];
	smp_word_t got_word;

	int errors;
	int frames_sent;
	int words_seen;
	int settings_done;
	int bypass_phases;
	int random_left;
	int burst_left;
	int idle_cycles;
	logic [15:0] ramp_l;
	logic [15:0] ramp_r;

	// receiver pacing
	logic        hold_ask;
	int          hold_left;
	int          pat_pos;
	logic [15:0] stall_pat;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic report(input string what);
		$display("tb: mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic int pick_level(input logic [31:0] word);
		int lo;
		int hi;
		lo = int'($signed(word[15:0]));
		hi = int'($signed(word[31:16]));
		case (cur_mode)
			CM_LEFT:  return lo * 256;
			CM_RIGHT: return hi * 256;
			default:  return (lo + hi) * 128;
		endcase
	endfunction

	function automatic logic [SMP_W-1:0] hermite_point(input int unsigned f);
		longint w0, w1, w2, w3, k3, k2, k1, ff, p, v;
		w0 = win[0];
		w1 = win[1];
		w2 = win[2];
		w3 = win[3];
		k3 = 3 * (w1 - w2) - w0 + w3;
		k2 = 4 * w2 + 2 * w0 - 5 * w1 - w3;
		k1 = w2 - w0;
		ff = longint'(f);
		// arithmetic shifts floor, the final one truncates toward zero
		p = ((k3 * ff) >>> FRAC_BITS) + k2;
		p = ((p * ff) >>> FRAC_BITS) + k1;
		v = w1 * (longint'(1) << (FRAC_BITS + 1)) + p * ff;
		if (v < 0) begin
			v = -((-v) >>> (FRAC_BITS + 1));
		end else begin
			v = v >>> (FRAC_BITS + 1);
		end
		if (v < SMP_MIN) v = SMP_MIN;
		if (v > SMP_MAX) v = SMP_MAX;
		return v[SMP_W-1:0];
	endfunction

	function automatic void emit_words();
		int n;
		smp_word_t w;
		n = 0;
		while (phase_acc < UNITY && n < MAX_RES) begin
			w.sample = hermite_point(phase_acc);
			n++;
			phase_acc = phase_acc + cur_rate;
			if (phase_acc > PH_TOP) phase_acc = PH_TOP;
			w.last = !(phase_acc < UNITY && n < MAX_RES);
			pending_samples.push_back(w);
		end
	endfunction

	function automatic void resample_frame(input logic [31:0] word, input logic rs);
		int lvl;
		lvl = pick_level(word);
		if (cur_rate == UNITY) begin
			pending_samples.push_back('{lvl[SMP_W-1:0], 1'b1});
			primes_due = 3;
			return;
		end
		if (rs) primes_due = 3;
		if (primes_due != 0) begin
			win[4 - primes_due] = lvl;
			primes_due--;
			if (primes_due != 0) return;
			phase_acc = 0;
			emit_words();
			return;
		end
		win[0] = win[1];
		win[1] = win[2];
		win[2] = win[3];
		win[3] = lvl;
		phase_acc = (phase_acc >= UNITY) ? phase_acc - UNITY : 0;
		if (phase_acc >= UNITY) return;
		emit_words();
	endfunction

	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = addr;
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// write a register, mirror it in the model and read it back
	task automatic write_reg(input logic idx, input logic [31:0] value);
		logic [APB_AW-1:0] addr;
		logic [APB_DW-1:0] rd;
		logic [APB_DW-1:0] want;
		addr = APB_AW'({idx, 2'b00});
		apb_access(1'b1, addr, value, rd);
		if (idx == REG_RATE) begin
			cur_rate = value[RATE_W-1:0];
			want = APB_DW'(value[RATE_W-1:0]);
			if (cur_rate == UNITY) bypass_phases++;
		end else begin
			cur_mode = value[MODE_W-1:0];
			want = APB_DW'(value[MODE_W-1:0]);
		end
		apb_access(1'b0, addr, '0, rd);
		if (rd !== want) report($sformatf("register %0d reads %h, wrote %h", idx, rd, want));
		settings_done++;
	endtask

	task automatic drain();
		@(negedge clk);
		din_if.valid = 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
	endtask

	// frames that give no word may still be in flight, so let them finish
	task automatic settle();
		drain();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic offer_frame(input logic [31:0] word, input logic rs, input logic typed,
			input logic [SMP_W-1:0] want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
			repeat (gap) begin
				@(negedge clk);
				din_if.valid = 1'b0;
			end
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		din_if.valid   = 1'b1;
		din_if.frame   = word;
		din_if.restart = rs;
		do @(posedge clk); while (!din_if.ready);
		resample_frame(word, rs);
		if (typed) begin
			void'(pending_samples.pop_back());
			pending_samples.push_back('{want, 1'b1});
		end
		burst_left--;
		frames_sent++;
	endtask

	function automatic logic [31:0] next_frame();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF7FFF;
					1: return 32'h80008000;
					2: return 32'h7FFF8000;
					default: return 32'h80007FFF;
				endcase
			end
			1, 2, 3: begin
				// slowly moving audio-like content
				ramp_l = ramp_l + 16'($urandom_range(0, 4095)) - 16'd2048;
				ramp_r = ramp_r + 16'($urandom_range(0, 4095)) - 16'd2048;
				return {ramp_r, ramp_l};
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic random_phase(input bit pressure);
		int n;
		int i;
		int drain_at;
		logic [RATE_W-1:0] r;
		logic rs;
		case ($urandom_range(0, 9))
			0: r = 20'd1024;
			1: r = 20'hFFFFF;
			2: r = RATE_W'(UNITY);
			3: r = ($urandom_range(0, 1) != 0) ? RATE_W'(UNITY - 1) : RATE_W'(UNITY + 1);
			4: r = RATE_W'($urandom_range(0, 1023));
			5, 6: r = RATE_W'($urandom_range(16384, 131072));
			default: r = RATE_W'($urandom_range(1024, 1048575));
		endcase
		if (pressure) r = 20'd16384;
		settle();
		write_reg(REG_RATE, 32'(r));
		write_reg(REG_MODE, 32'($urandom_range(0, 3)));
		n = (r < 20'd8192) ? $urandom_range(3, 6) : $urandom_range(8, 30);
		if (pressure && n < 12) n = 12;
		if (n > random_left) n = random_left;
		drain_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : -1;
		for (i = 0; i < n; i++) begin
			if (i == drain_at) drain();
			if (pressure && i == 2) hold_ask = 1'b1;
			rs = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0);
			offer_frame(next_frame(), rs, 1'b0, '0);
			random_left--;
		end
	endtask

	// output side: stall pattern of its own, plus one long hold on request
	always @(negedge clk) begin
		if (hold_ask) begin
			hold_ask  = 1'b0;
			hold_left = HOLD_LEN;
		end
		if (hold_left != 0) begin
			hold_left--;
			dout_if.ready = 1'b0;
		end else begin
			if (pat_pos == 0) begin
				stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0101);
			end
			dout_if.ready = stall_pat[pat_pos % 16];
			pat_pos = (pat_pos + 1) % 64;
		end
	end

	always @(posedge clk) begin
		if (arst_n && dout_if.valid && dout_if.ready) begin
			words_seen++;
			if (pending_samples.size() == 0) begin
				report($sformatf("word %h with nothing expected", dout_if.sample));
			end else begin
				got_word = pending_samples.pop_front();
				if (dout_if.sample !== got_word.sample) begin
					report($sformatf("sample %h, expected %h", dout_if.sample, got_word.sample));
				end
				if (dout_if.last !== got_word.last) begin
					report($sformatf("last %b, expected %b", dout_if.last, got_word.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG) begin
			$display("tb: timeout after %0d cycles with no word moving", WATCHDOG);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int k;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		din_if.valid   = 1'b0;
		din_if.frame   = '0;
		din_if.restart = 1'b0;
		dout_if.ready  = 1'b0;
		hold_ask       = 1'b0;
		hold_left      = 0;
		pat_pos        = 0;
		stall_pat      = 16'hFFFF;
		errors         = 0;
		frames_sent    = 0;
		words_seen     = 0;
		settings_done  = 0;
		bypass_phases  = 0;
		burst_left     = 0;
		idle_cycles    = 0;
		ramp_l         = '0;
		ramp_r         = '0;
		win            = '{0, 0, 0, 0};
		phase_acc      = 0;
		primes_due     = 3;
		cur_rate       = RATE_RST;
		cur_mode       = CM_AVG;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (k = 0; k < N_DIR; k++) begin
			case (directed_rows[k].kind)
				ROW_RATE: begin
					settle();
					write_reg(REG_RATE, directed_rows[k].value);
				end
				ROW_MODE: begin
					settle();
					write_reg(REG_MODE, directed_rows[k].value);
				end
				default: begin
					offer_frame(directed_rows[k].value, directed_rows[k].restart,
						directed_rows[k].typed, directed_rows[k].want);
				end
			endcase
		end

		random_left = N_RANDOM;
		k = 0;
		while (random_left > 0) begin
			random_phase(k == 1);
			k++;
		end

		drain();
		repeat (3 * SETTLE) @(posedge clk);

		$display("tb: %0d frames over %0d random phases, %0d words checked, %0d register writes",
			frames_sent, k, words_seen, settings_done);
		$display("tb: %0d bypass settings, one long output hold, mismatches %0d",
			bypass_phases, errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
